// ===== sv/pkfs_pkg.sv =====
// pkfs_pkg: shared constants, types and decrypt helpers for the key frequency solver
// no dependencies
package pkfs_pkg;

  localparam int unsigned MaxPeriodDef   = 32;
  localparam int unsigned CountWidthDef  = 16;
  localparam int unsigned WeightWidthDef = 16;
  localparam int unsigned NumLetters     = 26;
  localparam int unsigned HalfLetters    = 13;
  localparam int unsigned ScoreWidth     = 41;

  typedef enum logic [2:0] {
    OP_LOAD_WEIGHT = 3'd0,
    OP_LOAD_PT     = 3'd1,
    OP_LOAD_CT     = 3'd2,
    OP_LETTER      = 3'd3,
    OP_SOLVE       = 3'd4,
    OP_CLEAR       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_VIGENERE = 2'd0,
    MODE_BEAUFORT = 2'd1,
    MODE_PORTA    = 2'd2,
    MODE_QUAGMIRE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE    = 2'd0,
    CFG_VARIANT = 2'd1,
    CFG_PERIOD  = 2'd2
  } cfg_idx_e;

  // (a + b) mod 26 for a, b below 26
  function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'd26) s = s - 6'd26;
    return s[4:0];
  endfunction

  // (a - b) mod 26 for a, b below 26
  function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + 6'd26 - {1'b0, b};
    if (s >= 6'd26) s = s - 6'd26;
    return s[4:0];
  endfunction

  // porta: h = s/2, halves swap
  function automatic logic [4:0] porta(input logic [4:0] c, input logic [4:0] s);
    logic [4:0] h;
    logic [4:0] t;
    h = {1'b0, s[4:1]};
    if (c < 5'd13) begin
      t = c + h;
      if (t >= 5'd13) t = t - 5'd13;
      return t + 5'd13;
    end else begin
      t = c - 5'd13 + 5'd13 - h;
      if (t >= 5'd13) t = t - 5'd13;
      return t;
    end
  endfunction

endpackage

// ===== sv/pkfs_hist_mem.sv =====
// pkfs_hist_mem: histogram memory, one row of counts per column and letter
// depends on pkfs_pkg; synchronous read, one write port; the top level drives the clearing sweep
module pkfs_hist_mem #(
  parameter int unsigned MAX_PERIOD  = pkfs_pkg::MaxPeriodDef,
  parameter int unsigned COUNT_WIDTH = pkfs_pkg::CountWidthDef,
  parameter int unsigned AW          = 10
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output logic [COUNT_WIDTH-1:0] rd_data_o,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [COUNT_WIDTH-1:0] wr_data_i
);
  import pkfs_pkg::*;

  localparam int unsigned Depth = MAX_PERIOD * NumLetters;

  logic [COUNT_WIDTH-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== sv/periodic_key_frequency_solver.sv =====
// periodic_key_frequency_solver: top level, tables, letter counting and solve sequencer
// depends on pkfs_pkg and pkfs_hist_mem
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, operation/index/value  | input
//  out     | out_valid_o/out_ready_i, column/key_letter/.. | output
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i             | input
//
// loads, spare ops and ignored letters are taken in IDLE; a letter beat is a read-modify-write
// of the histogram memory: read in IDLE, then write back in INC; ready drops during the write back
// solve: per shift the 26 letters of the column are read (RD), the multiply pipe drains (MUL)
// and a compare follows (CMP); each column result then waits in WAIT; all reads share the one memory port
// reset and clear run a sweep zeroing all MAX_PERIOD*26 memory entries, ready low meanwhile
// a stalled result holds the output register; no new beat is taken until it is taken
module periodic_key_frequency_solver #(
  parameter int unsigned MAX_PERIOD   = pkfs_pkg::MaxPeriodDef,
  parameter int unsigned COUNT_WIDTH  = pkfs_pkg::CountWidthDef,
  parameter int unsigned WEIGHT_WIDTH = pkfs_pkg::WeightWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [4:0]  index_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  column_o,
  output logic [4:0]  key_letter_o,
  output logic [40:0] top_score_o,
  output logic        last_o
);
  import pkfs_pkg::*;

  localparam int unsigned Depth = MAX_PERIOD * NumLetters;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PrW   = COUNT_WIDTH + WEIGHT_WIDTH;
  localparam logic [ScoreWidth-1:0] ScoreMax = '1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_INC   = 8'b00000100,
    ST_RD    = 8'b00001000,  // issue reads for a shift
    ST_MUL   = 8'b00010000,  // drain the multiply pipe
    ST_CMP   = 8'b00100000,
    ST_OUT   = 8'b01000000,
    ST_WAIT  = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [1:0] mode_q;
  logic       variant_q;
  logic [5:0] period_q;

  // small tables, each read at a fixed place
  logic [WEIGHT_WIDTH-1:0] weight_q [NumLetters];
  logic [4:0]              pt_q     [NumLetters];
  logic [4:0]              ct_q     [NumLetters];
  logic [4:0]              pos_q    [NumLetters];

  // effective period, as a column count up to MAX_PERIOD
  logic [8:0] eff_p;
  always_comb begin
    if (period_q == 6'd0) eff_p = 9'd1;
    else if ({3'd0, period_q} > 9'(MAX_PERIOD)) eff_p = 9'(MAX_PERIOD);
    else eff_p = {3'd0, period_q};
  end

  logic [8:0]    colctr_q;
  logic [AW-1:0] clr_addr_q;
  logic [AW-1:0] inc_addr_q;
  logic [8:0]    col_q;      // solve column
  logic [4:0]    shift_q;
  logic [4:0]    let_q;      // letter issued
  logic [AW-1:0] row_base_q;

  // pipe: read issued (letter, valid) -> data + weight -> product -> accumulate
  logic       p1_v_q, p2_v_q;
  logic [WEIGHT_WIDTH-1:0] p1_wt_q;
  logic [PrW-1:0] p2_prod_q;
  logic [ScoreWidth-1:0] acc_q, best_q;
  logic [4:0] best_s_q;

  logic                   mem_rd_en, mem_wr_en;
  logic [AW-1:0]          mem_rd_addr, mem_wr_addr;
  logic [COUNT_WIDTH-1:0] mem_rd_data, mem_wr_data;

  pkfs_hist_mem #(
    .MAX_PERIOD (MAX_PERIOD),
    .COUNT_WIDTH(COUNT_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data)
  );

  // decrypted letter for letter let_q under shift_q
  logic [4:0] dec;
  always_comb begin
    case (mode_e'(mode_q))
      MODE_VIGENERE: dec = variant_q ? add26(let_q, shift_q) : sub26(let_q, shift_q);
      MODE_BEAUFORT: dec = sub26(shift_q, let_q);
      MODE_PORTA:    dec = porta(let_q, shift_q);
      default: begin
        if (variant_q) dec = pt_q[add26(pos_q[let_q] >= 5'd26 ? 5'd0 : pos_q[let_q], shift_q)];
        else           dec = pt_q[sub26(pos_q[let_q] >= 5'd26 ? 5'd0 : pos_q[let_q], shift_q)];
        if (dec >= 5'd26) dec = 5'd0;
      end
    endcase
  end

  logic in_fire;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  logic [AW-1:0] letter_addr;
  logic [8:0]    use_col;
  always_comb begin
    use_col     = (colctr_q >= eff_p) ? 9'd0 : colctr_q;
    letter_addr = AW'(use_col) * AW'(NumLetters) + AW'(value_i[4:0]);
  end

  // saturating accumulate, product clipped to the score range first
  logic [ScoreWidth-1:0] acc_add;
  always_comb begin
    logic [63:0]           prod_w;
    logic [ScoreWidth-1:0] prod_s;
    logic [ScoreWidth:0]   s;
    prod_w  = 64'(p2_prod_q);
    prod_s  = (prod_w > 64'(ScoreMax)) ? ScoreMax : prod_w[ScoreWidth-1:0];
    s       = {1'b0, acc_q} + {1'b0, prod_s};
    acc_add = s[ScoreWidth] ? ScoreMax : s[ScoreWidth-1:0];
  end

  always_comb begin
    state_d     = state_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = letter_addr;
    mem_wr_en   = 1'b0;
    mem_wr_addr = inc_addr_q;
    mem_wr_data = (&mem_rd_data) ? mem_rd_data : mem_rd_data + 1'b1;
    case (state_q)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr_q;
        mem_wr_data = '0;
        if (clr_addr_q == AW'(Depth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (op_e'(operation_i))
            OP_LETTER: if (value_i < 16'd26) begin
              mem_rd_en = 1'b1;
              state_d   = ST_INC;
            end
            OP_SOLVE: state_d = ST_RD;
            OP_CLEAR: state_d = ST_CLEAR;
            default: ;
          endcase
        end
      end
      ST_INC: begin
        mem_wr_en = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = row_base_q + AW'(let_q);
        if (let_q == 5'd25) state_d = ST_MUL;
      end
      ST_MUL: if (!p1_v_q && !p2_v_q) state_d = ST_CMP;
      ST_CMP: state_d = (shift_q == 5'd25) ? ST_OUT : ST_RD;
      ST_OUT: state_d = ST_WAIT;
      ST_WAIT: if (out_ready_i) begin
        state_d = (col_q + 9'd1 >= eff_p) ? ST_IDLE : ST_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      mode_q     <= 2'd0;
      variant_q  <= 1'b0;
      period_q   <= 6'd1;
      colctr_q   <= '0;
      clr_addr_q <= '0;
      p1_v_q     <= 1'b0;
      p2_v_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MODE:    mode_q    <= cfg_data_i[1:0];
          CFG_VARIANT: variant_q <= cfg_data_i[0];
          CFG_PERIOD:  period_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      else clr_addr_q <= '0;
      if (in_fire && op_e'(operation_i) == OP_LETTER && value_i < 16'd26) begin
        colctr_q <= (use_col + 9'd1 >= eff_p) ? 9'd0 : use_col + 9'd1;
      end
      if (in_fire && op_e'(operation_i) == OP_CLEAR) colctr_q <= '0;
      p1_v_q <= (state_q == ST_RD);
      p2_v_q <= p1_v_q;
      if (state_q == ST_OUT) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // payload and table registers
  always_ff @(posedge clk_i) begin
    if (in_fire && index_i < 5'd26) begin
      case (op_e'(operation_i))
        OP_LOAD_WEIGHT: weight_q[index_i] <= WEIGHT_WIDTH'(value_i);
        OP_LOAD_PT: if (value_i < 16'd26) pt_q[index_i] <= value_i[4:0];
        OP_LOAD_CT: if (value_i < 16'd26) begin
          ct_q[index_i]      <= value_i[4:0];
          pos_q[value_i[4:0]] <= index_i;
        end
        default: ;
      endcase
    end
    if (state_q == ST_IDLE) inc_addr_q <= letter_addr;
    p1_wt_q <= weight_q[dec];
    p2_prod_q <= PrW'(mem_rd_data) * PrW'(p1_wt_q);
    case (state_q)
      ST_IDLE: begin
        col_q <= '0; shift_q <= '0; let_q <= '0; row_base_q <= '0; acc_q <= '0;
      end
      ST_RD: let_q <= let_q + 5'd1;
      ST_CMP: begin
        if (shift_q == 5'd0 || acc_q > best_q) begin
          best_q <= acc_q; best_s_q <= shift_q;
        end
        shift_q <= shift_q + 5'd1;
        let_q   <= '0;
        acc_q   <= '0;
      end
      ST_OUT: begin
        column_o     <= col_q[4:0];
        key_letter_o <= ct_q[best_s_q];
        top_score_o  <= best_q;
        last_o       <= (col_q + 9'd1 >= eff_p);
      end
      ST_WAIT: if (out_ready_i) begin
        col_q      <= col_q + 9'd1;
        row_base_q <= row_base_q + AW'(NumLetters);
        shift_q    <= '0;
      end
      default: ;
    endcase
    if (p2_v_q) acc_q <= acc_add;
  end

`ifndef ASSERT_OFF
  a_out_only_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == ST_WAIT) else $error("result outside wait");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INC |=> !mem_wr_en || state_q == ST_IDLE) else $error("inc overlap");
  a_inc_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INC |-> $past(mem_rd_en)) else $error("write without read");
`endif

endmodule
